// ----- design/rmba_pkg.sv -----
// Shared constants, register codes and the tile request type of the mosaic block-average unit.
package rmba_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_TILE_DEF  = 64;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DEFAULT_TILE  = 24;
  localparam int QDEPTH_DEF    = 4;

  localparam int LUMA_W     = 8;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 7;
  localparam int FRAME_W    = 13;
  localparam int SUM_W      = 22;   // 255 * 127 * 127 fits
  localparam int PROD_W     = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_REGION_LEFT  = 3'd2,
    CFG_REGION_TOP   = 3'd3,
    CFG_REGION_RIGHT = 3'd4,
    CFG_REGION_BOT   = 3'd5,
    CFG_BLOCK_SIZE   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [SUM_W-1:0]   sum;
  } tile_req_t;

endpackage

// ----- design/rmba_front.sv -----
// Front end: config registers, raster position and tile tracking, column sum accumulation.
module rmba_front import rmba_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_TILE  = MAX_TILE_DEF,
  parameter int QDEPTH    = QDEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [LUMA_W-1:0]             in_luma,
  input  logic                          in_frame_start,
  input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
  output logic                          q_push,
  output tile_req_t                     q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (CW > COORD_W) ? CW : COORD_W;

  typedef enum logic [4:0] {
    RC_IDLE  = 5'b00001,
    RC_XINIT = 5'b00010,
    RC_X     = 5'b00100,
    RC_YINIT = 5'b01000,
    RC_Y     = 5'b10000
  } rc_state_t;

  rc_state_t rc_state_r;

  logic [FRAME_W-1:0] fw_cfg_r, fh_cfg_r;
  logic [COORD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [DIM_W-1:0]   bs_cfg_r;

  logic [CW-1:0]      col_r, k_r, bx_r;
  logic [COORD_W-1:0] row_r, by_r;
  logic [DIM_W-1:0]   cx_r, ry_r;
  logic [RW-1:0]      rem_r;

  // clamped config
  logic [13:0]        fw_w, xe_w;
  logic [FRAME_W-1:0] fh_w;
  logic [DIM_W-1:0]   bs;
  logic [CW-1:0]      x_end;
  logic [COORD_W-1:0] y_end, fhm1;

  always_comb begin
    if (fw_cfg_r == '0) fw_w = 14'd1;
    else if (int'(fw_cfg_r) > MAX_WIDTH) fw_w = 14'(MAX_WIDTH);
    else fw_w = 14'(fw_cfg_r);
    if (fh_cfg_r == '0) fh_w = 13'd1;
    else if (int'(fh_cfg_r) > MAX_HEIGHT) fh_w = 13'(MAX_HEIGHT);
    else fh_w = fh_cfg_r;
    if (bs_cfg_r == '0) bs = 7'd1;
    else if (int'(bs_cfg_r) > MAX_TILE) bs = DIM_W'(MAX_TILE);
    else bs = bs_cfg_r;
    xe_w  = ((fw_w - 14'd1) < 14'(right_r)) ? (fw_w - 14'd1) : 14'(right_r);
    x_end = CW'(xe_w);
    fhm1  = COORD_W'(fh_w - 13'd1);
    y_end = (fhm1 < bottom_r) ? fhm1 : bottom_r;
  end

  // current pixel view
  logic               acc;
  logic [CW-1:0]      cur_col, cur_k, cur_bx;
  logic [COORD_W-1:0] cur_row, cur_by;
  logic [DIM_W-1:0]   cur_cx, cur_ry, w, h;
  logic [13:0]        xd, nc;
  logic [COORD_W-1:0] yd;
  logic [FRAME_W-1:0] nr;
  logic               in_reg, first, last, wrap;
  logic [CW-1:0]      col_nxt, k_nxt, bx_nxt;
  logic [COORD_W-1:0] row_nxt, by_nxt;
  logic [DIM_W-1:0]   cx_nxt, ry_nxt;

  logic               s1_valid_r, s1_first_r, s1_last_r, s1_hit_r;
  logic [CW-1:0]      s1_k_r;
  logic [LUMA_W-1:0]  s1_luma_r;
  tile_req_t          s1_tile_r;
  logic [SUM_W-1:0]   rd_r, fwd_r, s1_sum, s1_base;

  assign in_full = (rc_state_r != RC_IDLE) ||
                   ((int'(q_count) + int'(s1_valid_r)) >= QDEPTH);
  assign acc = in_push && !in_full;

  always_comb begin
    cur_col = in_frame_start ? '0 : col_r;
    cur_row = in_frame_start ? '0 : row_r;
    cur_cx  = in_frame_start ? '0 : cx_r;
    cur_k   = in_frame_start ? '0 : k_r;
    cur_bx  = in_frame_start ? CW'(left_r) : bx_r;
    cur_ry  = in_frame_start ? '0 : ry_r;
    cur_by  = in_frame_start ? top_r : by_r;

    in_reg = (14'(cur_col) >= 14'(left_r)) && (cur_col < x_end) &&
             (cur_row >= top_r) && (cur_row < y_end);
    xd = 14'(x_end) - 14'(cur_bx);
    w  = (xd < 14'(bs)) ? DIM_W'(xd) : bs;
    yd = y_end - cur_by;
    h  = (yd < COORD_W'(bs)) ? DIM_W'(yd) : bs;
    first = (cur_cx == '0) && (cur_ry == '0);
    last  = (cur_cx == w - 7'd1) && (cur_ry == h - 7'd1);

    nc   = 14'(cur_col) + 14'd1;
    wrap = nc >= fw_w;
    nr   = 13'(cur_row) + 13'd1;
    col_nxt = wrap ? '0 : CW'(nc);
    row_nxt = wrap ? ((nr >= fh_w) ? '0 : COORD_W'(nr)) : cur_row;

    // tile column tracking restarts at the region's left edge every row
    cx_nxt = cur_cx;
    k_nxt  = cur_k;
    bx_nxt = cur_bx;
    if (14'(col_nxt) == 14'(left_r)) begin
      cx_nxt = '0;
      k_nxt  = '0;
      bx_nxt = CW'(left_r);
    end else if (14'(col_nxt) > 14'(left_r)) begin
      if (cur_cx + 7'd1 == bs) begin
        cx_nxt = '0;
        k_nxt  = cur_k + CW'(1);
        bx_nxt = CW'(14'(cur_bx) + 14'(bs));
      end else begin
        cx_nxt = cur_cx + 7'd1;
      end
    end

    ry_nxt = cur_ry;
    by_nxt = cur_by;
    if (wrap) begin
      if (row_nxt == top_r) begin
        ry_nxt = '0;
        by_nxt = top_r;
      end else if (row_nxt > top_r) begin
        if (cur_ry + 7'd1 == bs) begin
          ry_nxt = '0;
          by_nxt = COORD_W'(13'(cur_by) + 13'(bs));
        end else begin
          ry_nxt = cur_ry + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_cfg_r   <= 13'd640;
      fh_cfg_r   <= 13'd480;
      left_r     <= '0;
      top_r      <= '0;
      right_r    <= '0;
      bottom_r   <= '0;
      bs_cfg_r   <= DIM_W'(DEFAULT_TILE);
      col_r      <= '0;
      row_r      <= '0;
      cx_r       <= '0;
      k_r        <= '0;
      bx_r       <= '0;
      ry_r       <= '0;
      by_r       <= '0;
      rem_r      <= '0;
      rc_state_r <= RC_IDLE;
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        cx_r  <= cx_nxt;
        k_r   <= k_nxt;
        bx_r  <= bx_nxt;
        ry_r  <= ry_nxt;
        by_r  <= by_nxt;
      end
      if (cfg_we) begin
        // any write restarts the rebuild from scratch
        rc_state_r <= RC_XINIT;
        case (cfg_reg_t'(cfg_index))
          CFG_FRAME_WIDTH:  fw_cfg_r <= cfg_data;
          CFG_FRAME_HEIGHT: fh_cfg_r <= cfg_data;
          CFG_REGION_LEFT:  left_r   <= COORD_W'(cfg_data);
          CFG_REGION_TOP:   top_r    <= COORD_W'(cfg_data);
          CFG_REGION_RIGHT: right_r  <= COORD_W'(cfg_data);
          CFG_REGION_BOT:   bottom_r <= COORD_W'(cfg_data);
          CFG_BLOCK_SIZE:   bs_cfg_r <= DIM_W'(cfg_data);
          default: ;
        endcase
      end else begin
        // rebuild tile counters for the held position by repeated subtraction
        case (rc_state_r)
          RC_IDLE: ;
          RC_XINIT: begin
            rem_r      <= (14'(col_r) >= 14'(left_r)) ? RW'(14'(col_r) - 14'(left_r)) : '0;
            k_r        <= '0;
            bx_r       <= CW'(left_r);
            rc_state_r <= RC_X;
          end
          RC_X: begin
            if (rem_r >= RW'(bs)) begin
              rem_r <= rem_r - RW'(bs);
              k_r   <= k_r + CW'(1);
              bx_r  <= CW'(14'(bx_r) + 14'(bs));
            end else begin
              cx_r       <= DIM_W'(rem_r);
              rc_state_r <= RC_YINIT;
            end
          end
          RC_YINIT: begin
            rem_r      <= (row_r >= top_r) ? RW'(row_r - top_r) : '0;
            by_r       <= top_r;
            rc_state_r <= RC_Y;
          end
          RC_Y: begin
            if (rem_r >= RW'(bs)) begin
              rem_r <= rem_r - RW'(bs);
              by_r  <= COORD_W'(13'(by_r) + 13'(bs));
            end else begin
              ry_r       <= DIM_W'(rem_r);
              rc_state_r <= RC_IDLE;
            end
          end
          default: rc_state_r <= RC_IDLE;
        endcase
      end
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc && in_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_first_r      <= first;
      s1_last_r       <= last;
      s1_k_r          <= cur_k;
      s1_luma_r       <= in_luma;
      s1_hit_r        <= s1_valid_r && (s1_k_r == cur_k);
      s1_tile_r.x     <= COORD_W'(cur_bx);
      s1_tile_r.y     <= cur_by;
      s1_tile_r.w     <= w;
      s1_tile_r.h     <= h;
      s1_tile_r.sum   <= '0;
    end
    if (s1_valid_r) fwd_r <= s1_sum;
  end

  assign s1_base = s1_first_r ? '0 : (s1_hit_r ? fwd_r : rd_r);
  assign s1_sum  = s1_base + SUM_W'(s1_luma_r);

  logic [SUM_W-1:0] sums_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (acc) rd_r <= sums_mem[cur_k];
    if (s1_valid_r) sums_mem[s1_k_r] <= s1_sum;
  end

  assign q_push = s1_valid_r && s1_last_r;
  always_comb begin
    q_data     = s1_tile_r;
    q_data.sum = s1_sum;
  end

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(acc))
    else $error("accumulate stage without an accepted pixel");
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_full)
    else $error("input open while tile counters rebuild");

endmodule

// ----- design/rmba_queue.sv -----
// Small register queue of tile requests between front and back end.
module rmba_queue import rmba_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tile_req_t                    push_data,
  input  logic                         pop,
  output tile_req_t                    pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  tile_req_t                    slot_r [DEPTH];
  logic [AW-1:0]                wp_r, rp_r;
  logic [NW-1:0]                count_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      if (push && !pop) count_r <= count_r + NW'(1);
      else if (!push && pop) count_r <= count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  assign pop_data = slot_r[rp_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (int'(count_r) < DEPTH) || pop)
    else $error("tile queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("tile queue underflow");

endmodule

// ----- design/rmba_back.sv -----
// Back end: area product, radix-2 mean division with saturation, result register.
module rmba_back import rmba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tile_req_t           q_data,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic [COORD_W-1:0]  out_tile_x,
  output logic [COORD_W-1:0]  out_tile_y,
  output logic [DIM_W-1:0]    out_tile_w,
  output logic [DIM_W-1:0]    out_tile_h,
  output logic [LUMA_W-1:0]   out_tile_mean
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_SAT  = 5'b00100,
    B_DIV  = 5'b01000,
    B_HOLD = 5'b10000
  } back_state_t;

  back_state_t          state_r;
  tile_req_t            tile_r;
  logic [PROD_W-1:0]    div_r;
  logic [PROD_W+6:0]    dsh_r;
  logic [SUM_W-1:0]     rem_r;
  logic [LUMA_W-1:0]    quo_r;
  logic [2:0]           cnt_r;
  logic                 out_valid_r;
  logic                 take_out;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign take_out = (state_r == B_HOLD) && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: if (!q_empty) state_r <= B_MUL;
        B_MUL:  state_r <= B_SAT;
        B_SAT:  state_r <= (tile_r.sum >= {div_r, 8'd0}) ? B_HOLD : B_DIV;
        B_DIV:  if (cnt_r == '0) state_r <= B_HOLD;
        B_HOLD: if (take_out) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
      if (take_out) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (!q_empty) tile_r <= q_data;
      B_MUL:  div_r <= {7'd0, tile_r.w} * {7'd0, tile_r.h};
      B_SAT: begin
        rem_r <= tile_r.sum;
        dsh_r <= {div_r, 7'd0};
        cnt_r <= 3'd7;
        quo_r <= (tile_r.sum >= {div_r, 8'd0}) ? 8'hFF : 8'd0;
      end
      B_DIV: begin
        if (rem_r >= SUM_W'(dsh_r)) begin
          rem_r <= rem_r - SUM_W'(dsh_r);
          quo_r <= {quo_r[LUMA_W-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[LUMA_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 3'd1;
      end
      B_HOLD: begin
        if (take_out) begin
          out_tile_x    <= tile_r.x;
          out_tile_y    <= tile_r.y;
          out_tile_w    <= tile_r.w;
          out_tile_h    <= tile_r.h;
          out_tile_mean <= quo_r;
        end
      end
      default: ;
    endcase
  end

  assign out_empty = !out_valid_r;

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < {dsh_r, 1'b0}))
    else $error("partial remainder out of range");

endmodule

// ----- design/region_mosaic_block_average_unit.sv -----
// Mosaic block-average top level: front end, tile request queue and divider back end.
// Throughput: one pixel per cycle while the tile queue has room and no counter rebuild runs;
//   the back end divides one queued tile at a time and waits while the last result is not taken.
// Result path: accumulate stage, tile queue, then MUL, SAT, DIV (unless saturated), HOLD.
// Config write: input held off while the tile counters are rebuilt by repeated subtraction.
// Reset (rst_n low, synchronous): config defaults, position (0,0); sums memory not cleared.
module region_mosaic_block_average_unit import rmba_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_TILE  = MAX_TILE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [LUMA_W-1:0]     in_luma,
  input  logic                  in_frame_start,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [COORD_W-1:0]    out_tile_x,
  output logic [COORD_W-1:0]    out_tile_y,
  output logic [DIM_W-1:0]      out_tile_w,
  output logic [DIM_W-1:0]      out_tile_h,
  output logic [LUMA_W-1:0]     out_tile_mean
);

  // tile request queue between accumulation and division
  tile_req_t                         q_in, q_out;
  logic                              q_push, q_pop, q_empty;
  logic [$clog2(QDEPTH_DEF+1)-1:0]   q_count;

  // front: position tracking and per-tile-column running sums
  rmba_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_TILE  (MAX_TILE),
    .QDEPTH    (QDEPTH_DEF)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_luma        (in_luma),
    .in_frame_start (in_frame_start),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  rmba_queue #(
    .DEPTH (QDEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .count     (q_count)
  );

  // back: mean = sum / (w*h), saturated to 255
  rmba_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_tile_x    (out_tile_x),
    .out_tile_y    (out_tile_y),
    .out_tile_w    (out_tile_w),
    .out_tile_h    (out_tile_h),
    .out_tile_mean (out_tile_mean)
  );

endmodule
